/* rtl/core/rcat_pkg.sv */
package rcat_pkg;

	// Fixed field widths on the stream ports
	localparam int IN_SEQ_BITS   = 48;
	localparam int LEN_BITS      = 11;
	localparam int PEND_BITS     = 5;
	localparam int OUTCOME_BITS  = 3;
	localparam int IN_DATA_BITS  = 64;
	localparam int OUT_DATA_BITS = 56;

	// Per-segment result code
	typedef enum logic [OUTCOME_BITS-1:0] {
		OUT_IN_ORDER  = 3'd0,
		OUT_STALE     = 3'd1,
		OUT_STORED    = 3'd2,
		OUT_DUPLICATE = 3'd3,
		OUT_FULL      = 3'd4
	} outcome_t;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_END,
		ST_CLASS,
		ST_DRAIN,
		ST_SEARCH,
		ST_DECIDE,
		ST_SHIFT,
		ST_INSERT,
		ST_FINISH
	} state_t;

	// Shared sequence unit: plain saturating add, or segment end
	typedef enum logic {
		UM_ADD,
		UM_END
	} unit_mode_t;

	// Compare flags from the shared sequence unit
	typedef struct packed {
		logic follows;  // c == a + 1 and a below the top of the range
		logic eq;       // c == a
		logic le;       // c <= a
	} unit_flags_t;

endpackage

/* rtl/core/rcat_ram.sv */
module rcat_ram #(
	parameter int WIDTH = 59,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                      wr_data,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                      rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

/* rtl/core/rcat_seq_unit.sv */
module rcat_seq_unit #(
	parameter int SEQ_BITS = 48
) (
	input  rcat_pkg::unit_mode_t          mode,
	input  logic [SEQ_BITS-1:0]           a,
	input  logic [rcat_pkg::LEN_BITS-1:0] b,
	input  logic [SEQ_BITS-1:0]           c,
	output logic [SEQ_BITS-1:0]           sum,
	output rcat_pkg::unit_flags_t         flags
);
	import rcat_pkg::*;

	logic                dec;
	logic [SEQ_BITS-1:0] addend;
	logic [SEQ_BITS:0]   total;
	logic [SEQ_BITS-1:0] a_inc;

	// Segment end of an empty segment is start minus one, wrapped
	assign dec = (mode == UM_END) && (b == '0);

	always_comb begin
		if (dec) begin
			addend = '1;
		end else if (mode == UM_END) begin
			addend = SEQ_BITS'(b) - SEQ_BITS'(1);
		end else begin
			addend = SEQ_BITS'(b);
		end
	end

	// Saturating add, no saturation on the wrapped decrement
	assign total = {1'b0, a} + {1'b0, addend};
	assign sum   = (total[SEQ_BITS] && !dec) ? '1 : total[SEQ_BITS-1:0];

	// Compares
	assign a_inc         = a + SEQ_BITS'(1);
	assign flags.follows = (a != '1) && (c == a_inc);
	assign flags.eq      = (c == a);
	assign flags.le      = (c <= a);

endmodule

/* rtl/core/reorder_cumulative_ack_tracker.sv */
// Reassembly tracker for one byte-numbered flow.
// Input stream (s_*): one word per segment; s_tdata holds the first byte's
// sequence number and the payload length, s_tlast marks the flow's final
// segment. Output stream (m_*): one word per segment with the cumulative ack
// and the count of held segments, the outcome code on m_tuser, and m_tlast
// high on the single word at which the flow became contiguous.
// Out-of-order segments sit in a RAM table, sorted by start, used as a ring:
// draining advances the head, inserting shifts the tail up one entry a cycle.
// All sequence math runs through one shared add/compare unit under a
// sequencer, so the block takes one segment at a time; s_tready is high only
// while idle. A stale segment passes the END, CLASS and FINISH states, and
// its word is loaded into the output register as the block returns to idle.
// Held entries are compared while draining or searching and shifted to open
// a slot; DECIDE checks for room and INSERT stores the new segment.
// The RAM read port sets the one-entry-per-cycle walk.
// The result sits in an output register; if the receiver stalls, the block
// holds the finished word and waits before loading the next one, while the
// next segment may already be accepted and worked on.
// Reset clears the ack, the last-byte mark, the completion flag and the
// table count; table contents are not cleared and no sweep is needed.
module reorder_cumulative_ack_tracker #(
	parameter int HOLD_DEPTH = 16,
	parameter int SEQ_BITS   = 48
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [rcat_pkg::IN_DATA_BITS-1:0]    s_tdata,  // seq_start[47:0], payload_len[58:48]
	input  logic                                 s_tlast,  // is_last
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [rcat_pkg::OUT_DATA_BITS-1:0]   m_tdata,  // ack_point[47:0], pending_count[52:48]
	output logic [rcat_pkg::OUTCOME_BITS-1:0]    m_tuser,  // outcome[2:0]
	output logic                                 m_tlast   // flow_complete
);
	import rcat_pkg::*;

	localparam int IDX_W   = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
	localparam int CNT_W   = $clog2(HOLD_DEPTH + 1);
	localparam int PH_W    = CNT_W + 1;
	localparam int ENTRY_W = SEQ_BITS + LEN_BITS;

	// Logical table index to RAM address, relative to the ring head
	function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] hd,
			input logic [CNT_W-1:0] lg);
		logic [PH_W-1:0] s;
		s = PH_W'(hd) + PH_W'(lg);
		if (s >= PH_W'(HOLD_DEPTH)) begin
			s = s - PH_W'(HOLD_DEPTH);
		end
		return s[IDX_W-1:0];
	endfunction

	state_t              state_q, state_d;
	logic [SEQ_BITS-1:0] seq_q, end_q, cum_q, lastb_q;
	logic [LEN_BITS-1:0] len_q;
	logic                last_flag_q, done_q;
	logic [IDX_W-1:0]    head_q;
	logic [CNT_W-1:0]    cnt_q, pos_q, sh_q;
	outcome_t            outcome_q;

	logic                m_valid_q;
	logic [IN_SEQ_BITS-1:0] ack_out_q;
	logic [PEND_BITS-1:0] pend_out_q;
	outcome_t            outc_out_q;
	logic                cmp_out_q;

	logic [63:0]         seq_wide;
	logic [63:0]         cum_wide;
	logic                out_free;
	logic                complete;
	logic [CNT_W:0]      pos_next;
	logic [IDX_W:0]      head_inc;

	// Shared unit operands and results
	unit_mode_t          u_mode;
	logic [SEQ_BITS-1:0] u_a, u_c, u_sum;
	logic [LEN_BITS-1:0] u_b;
	unit_flags_t         u_flags;

	// Table RAM
	logic                ram_we;
	logic [IDX_W-1:0]    ram_waddr, ram_raddr;
	logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;
	logic [CNT_W-1:0]    rd_log, wr_log;
	logic [SEQ_BITS-1:0] ent_start;
	logic [LEN_BITS-1:0] ent_len;

	rcat_seq_unit #(
		.SEQ_BITS(SEQ_BITS)
	) u_unit (
		.mode (u_mode),
		.a    (u_a),
		.b    (u_b),
		.c    (u_c),
		.sum  (u_sum),
		.flags(u_flags)
	);

	rcat_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(HOLD_DEPTH)
	) u_table (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(ram_waddr),
		.wr_data(ram_wdata),
		.rd_addr(ram_raddr),
		.rd_data(ram_rdata)
	);

	assign ent_start = ram_rdata[ENTRY_W-1:LEN_BITS];
	assign ent_len   = ram_rdata[LEN_BITS-1:0];
	assign seq_wide  = 64'(s_tdata[IN_SEQ_BITS-1:0]);
	assign cum_wide  = 64'(cum_q);
	assign out_free  = !m_valid_q || m_tready;
	assign complete  = (lastb_q != '0) && u_flags.le && !done_q;
	assign pos_next  = {1'b0, pos_q} + (CNT_W+1)'(1);
	assign head_inc  = {1'b0, head_q} + (IDX_W+1)'(1);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_END;
				end
			end
			ST_END: begin
				state_d = ST_CLASS;
			end
			ST_CLASS: begin
				if (u_flags.follows) begin
					state_d = (cnt_q != '0) ? ST_DRAIN : ST_FINISH;
				end else if (u_flags.le) begin
					state_d = ST_FINISH;
				end else begin
					state_d = (cnt_q != '0) ? ST_SEARCH : ST_DECIDE;
				end
			end
			ST_DRAIN: begin
				if (!u_flags.follows || cnt_q == CNT_W'(1)) begin
					state_d = ST_FINISH;
				end
			end
			ST_SEARCH: begin
				if (u_flags.eq) begin
					state_d = ST_FINISH;
				end else if (!u_flags.le || pos_next >= {1'b0, cnt_q}) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (cnt_q >= CNT_W'(HOLD_DEPTH)) begin
					state_d = ST_FINISH;
				end else if (cnt_q > pos_q) begin
					state_d = ST_SHIFT;
				end else begin
					state_d = ST_INSERT;
				end
			end
			ST_SHIFT: begin
				if (sh_q <= pos_q) begin
					state_d = ST_INSERT;
				end
			end
			ST_INSERT: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Datapath controls: unit operands, RAM ports, ready
	always_comb begin
		s_tready = 1'b0;
		u_mode   = UM_ADD;
		u_a      = cum_q;
		u_b      = '0;
		u_c      = seq_q;
		rd_log   = '0;
		wr_log   = pos_q;
		ram_we   = 1'b0;
		ram_wdata = {seq_q, len_q};
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
			end
			ST_END: begin
				u_mode = UM_END;
				u_a    = seq_q;
				u_b    = len_q;
			end
			ST_CLASS: begin
				rd_log = '0;
			end
			ST_DRAIN: begin
				u_b    = ent_len;
				u_c    = ent_start;
				rd_log = CNT_W'(1);
			end
			ST_SEARCH: begin
				u_a    = seq_q;
				u_c    = ent_start;
				rd_log = pos_next[CNT_W-1:0];
			end
			ST_DECIDE: begin
				rd_log = cnt_q - CNT_W'(1);
			end
			ST_SHIFT: begin
				rd_log    = sh_q - CNT_W'(1);
				wr_log    = sh_q + CNT_W'(1);
				ram_we    = 1'b1;
				ram_wdata = ram_rdata;
			end
			ST_INSERT: begin
				ram_we = 1'b1;
			end
			ST_FINISH: begin
				u_c = lastb_q;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	assign ram_raddr = phys(head_q, rd_log);
	assign ram_waddr = phys(head_q, wr_log);

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cum_q   <= '0;
			lastb_q <= '0;
			done_q  <= 1'b0;
			cnt_q   <= '0;
			head_q  <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_END: begin
					if (last_flag_q) begin
						lastb_q <= u_sum;
					end
				end
				ST_CLASS: begin
					if (u_flags.follows) begin
						cum_q <= end_q;
					end
				end
				ST_DRAIN: begin
					if (u_flags.follows) begin
						cum_q  <= u_sum;
						cnt_q  <= cnt_q - CNT_W'(1);
						head_q <= (head_inc == (IDX_W+1)'(HOLD_DEPTH)) ? '0 :
							head_inc[IDX_W-1:0];
					end
				end
				ST_INSERT: begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
				ST_FINISH: begin
					if (out_free && complete) begin
						done_q <= 1'b1;
					end
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

	// Segment and walk registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				seq_q       <= seq_wide[SEQ_BITS-1:0];
				len_q       <= s_tdata[IN_SEQ_BITS +: LEN_BITS];
				last_flag_q <= s_tlast;
			end
			ST_END: begin
				end_q <= u_sum;
			end
			ST_CLASS: begin
				pos_q <= '0;
				if (u_flags.follows) begin
					outcome_q <= OUT_IN_ORDER;
				end else if (u_flags.le) begin
					outcome_q <= OUT_STALE;
				end
			end
			ST_SEARCH: begin
				if (u_flags.eq) begin
					outcome_q <= OUT_DUPLICATE;
				end else if (u_flags.le) begin
					pos_q <= pos_next[CNT_W-1:0];
				end
			end
			ST_DECIDE: begin
				sh_q <= cnt_q - CNT_W'(1);
				if (cnt_q >= CNT_W'(HOLD_DEPTH)) begin
					outcome_q <= OUT_FULL;
				end
			end
			ST_SHIFT: begin
				sh_q <= sh_q - CNT_W'(1);
			end
			ST_INSERT: begin
				outcome_q <= OUT_STORED;
			end
			default: begin
				sh_q <= sh_q;
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == ST_FINISH && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && out_free) begin
			ack_out_q  <= cum_wide[IN_SEQ_BITS-1:0];
			pend_out_q <= PEND_BITS'(cnt_q);
			outc_out_q <= outcome_q;
			cmp_out_q  <= complete;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(OUT_DATA_BITS - IN_SEQ_BITS - PEND_BITS){1'b0}}, pend_out_q, ack_out_q};
	assign m_tuser  = outc_out_q;
	assign m_tlast  = cmp_out_q;

endmodule

/* rtl/core/rcat_checker.sv */
module rcat_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               s_tvalid,
	input logic                               s_tready,
	input logic                               m_tvalid,
	input logic                               m_tready,
	input logic [rcat_pkg::OUT_DATA_BITS-1:0] m_tdata,
	input logic                               m_tlast
);
	import rcat_pkg::*;

	logic [IN_SEQ_BITS-1:0] ack_seen_q;
	logic                   done_seen_q;

	// Track last delivered ack and whether completion was reported
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_seen_q  <= '0;
			done_seen_q <= 1'b0;
		end else if (m_tvalid && m_tready) begin
			ack_seen_q <= m_tdata[IN_SEQ_BITS-1:0];
			if (m_tlast) begin
				done_seen_q <= 1'b1;
			end
		end
	end

	// Stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result word changed while stalled");

	// One segment at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("accepted a second segment while busy");

	// Cumulative ack never moves back
	a_ack_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[IN_SEQ_BITS-1:0] >= ack_seen_q)
		else $error("ack went backwards");

	// Completion is reported once
	a_complete_once: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> !done_seen_q)
		else $error("flow completion reported twice");

endmodule

bind reorder_cumulative_ack_tracker rcat_checker u_rcat_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast)
);
